FILE: rtl/core/uart_rx_line_assembler_unit_assert.svh
// Assertion macros for the UART line assembler
`ifndef UART_RX_LINE_ASSEMBLER_UNIT_ASSERT_SVH
`define UART_RX_LINE_ASSEMBLER_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define URLA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Check that a trigger implies a consequence in the same cycle
`define URLA_ASSERT_IMPLIES(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("assertion failed: implication");

`endif

FILE: rtl/core/urla_pkg.sv
// Package with types and constants of the UART line assembler
`timescale 1ns / 1ps

package urla_pkg;

    localparam int LINE_BUFFER_BYTES = 128;
    localparam int LINE_COUNT_W      = 12;
    localparam int TICK_W            = 17;
    localparam int BIT_TICKS_W       = 16;
    localparam int BIT_INDEX_W       = 4;
    localparam int DATA_BITS         = 8;

    localparam logic [LINE_COUNT_W-1:0] FULL_LEVEL = LINE_COUNT_W'(LINE_BUFFER_BYTES - 1);
    localparam logic [BIT_INDEX_W-1:0]  LAST_BIT   = BIT_INDEX_W'(DATA_BITS);

    localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RESET = 16'd104;
    localparam logic [7:0]             TERM_RESET      = 8'd0;

    // (x * RECIP_THIRD) >> RECIP_SHIFT equals x / 3 for every 16-bit x
    localparam logic [16:0] RECIP_THIRD = 17'h0AAAB;
    localparam int          RECIP_SHIFT = 17;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_STOP = 2'd2
    } rx_phase_t;

    typedef enum logic {
        CFG_BIT_TICKS = 1'b0,
        CFG_LINE_TERM = 1'b1
    } cfg_index_t;

endpackage

FILE: rtl/core/uart_rx_line_assembler_unit.sv
// Top level of the UART line assembler: 8N1 receiver, byte filter and line framing
//
// Channel   Dir  Fields (low bit first)             Transaction when
// s_axis    in   tdata[0] rx_level                 s_axis_tvalid & s_axis_tready
// m_axis    out  tdata[7:0] data_byte, tlast       m_axis_tvalid & m_axis_tready
//                line_end, tuser full_flush
// cfg       in   cfg_index, cfg_wdata[15:0]        cfg_we
//
// A sample is taken every cycle while the
// result register is empty or being drained in the same cycle.
// A result appears in the output register in the cycle after the sample that ends the frame.
// The start delay bit_ticks/3 + bit_ticks is computed at the bit_ticks write.
// Reset clears the phase, counters and the output valid flag; no clearing pass.
// A stalled result stalls the sample input.
`timescale 1ns / 1ps

module uart_rx_line_assembler_unit
    import urla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] rx_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tlast,   // line_end
    output logic        m_axis_tuser,   // [0] full_flush
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    `include "uart_rx_line_assembler_unit_assert.svh"

    logic [TICK_W-1:0]       start_ticks_reg,  start_ticks_next;
    logic [BIT_TICKS_W-1:0]  bit_reload_reg,   bit_reload_next;
    logic [7:0]              term_reg,         term_next;

    rx_phase_t               phase_reg,        phase_next;
    logic [TICK_W-1:0]       tick_count_reg,   tick_count_next;
    logic [7:0]              shift_byte_reg,   shift_byte_next;
    logic [BIT_INDEX_W-1:0]  bit_index_reg,    bit_index_next;
    logic [LINE_COUNT_W-1:0] line_count_reg,   line_count_next;

    logic                    out_valid_reg,    out_valid_next;
    logic [7:0]              out_byte_reg,     out_byte_next;
    logic                    out_last_reg,     out_last_next;
    logic                    out_full_reg,     out_full_next;

    logic                    in_accept;
    logic                    level;
    logic                    emit;
    logic [TICK_W-1:0]       tick_dec;
    logic [7:0]              shifted;
    logic [BIT_INDEX_W-1:0]  index_inc;
    logic [LINE_COUNT_W-1:0] count_inc;
    logic                    hit_full;
    logic                    hit_term;
    logic [32:0]             third_prod;
    logic [TICK_W-1:0]       start_sum;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign level         = s_axis_tdata[0];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_full_reg;

    // configuration: precompute the start delay on a bit_ticks write, store the terminator on a line_term write
    always_comb
    begin
        third_prod       = {17'd0, cfg_wdata} * {16'd0, RECIP_THIRD};
        start_sum        = TICK_W'(third_prod >> RECIP_SHIFT) + {1'b0, cfg_wdata};
        start_ticks_next = start_ticks_reg;
        bit_reload_next  = bit_reload_reg;
        term_next        = term_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BIT_TICKS:
                begin
                    start_ticks_next = (start_sum == '0) ? TICK_W'(1) : start_sum;
                    bit_reload_next  = (cfg_wdata == '0) ? BIT_TICKS_W'(1) : cfg_wdata;
                end
                CFG_LINE_TERM:
                begin
                    term_next = cfg_wdata[7:0];
                end
                default:
                begin
                    term_next = term_reg;
                end
            endcase
        end
    end

    // receiver next state and result
    always_comb
    begin
        tick_dec        = tick_count_reg - TICK_W'(1);
        shifted         = {level, shift_byte_reg[7:1]};
        index_inc       = bit_index_reg + BIT_INDEX_W'(1);
        count_inc       = line_count_reg + LINE_COUNT_W'(1);
        hit_full        = (count_inc >= FULL_LEVEL);
        hit_term        = (term_reg != 8'd0) && (shift_byte_reg == term_reg);

        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        shift_byte_next = shift_byte_reg;
        bit_index_next  = bit_index_reg;
        line_count_next = line_count_reg;
        emit            = 1'b0;

        if (in_accept)
        begin
            case (phase_reg)
                PH_DATA:
                begin
                    if (tick_dec == '0)
                    begin
                        shift_byte_next = shifted;
                        bit_index_next  = index_inc;
                        tick_count_next = {1'b0, bit_reload_reg};
                        if (index_inc >= LAST_BIT)
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    else
                    begin
                        tick_count_next = tick_dec;
                    end
                end
                PH_STOP:
                begin
                    tick_count_next = tick_dec;
                    if (tick_dec == '0)
                    begin
                        phase_next = PH_IDLE;
                        if (shift_byte_reg != 8'd0)
                        begin
                            emit            = 1'b1;
                            line_count_next = (hit_full || hit_term) ? '0 : count_inc;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (!level)
                    begin
                        phase_next      = PH_DATA;
                        shift_byte_next = 8'd0;
                        bit_index_next  = '0;
                        tick_count_next = start_ticks_reg;
                    end
                end
            endcase
        end

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_full_next  = out_full_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = shift_byte_reg;
            out_last_next  = hit_full || hit_term;
            out_full_next  = hit_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_ticks_reg <= TICK_W'(BIT_TICKS_RESET / 3 + BIT_TICKS_RESET);
            bit_reload_reg  <= BIT_TICKS_RESET;
            term_reg        <= TERM_RESET;
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= '0;
            shift_byte_reg  <= '0;
            bit_index_reg   <= '0;
            line_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            start_ticks_reg <= start_ticks_next;
            bit_reload_reg  <= bit_reload_next;
            term_reg        <= term_next;
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            shift_byte_reg  <= shift_byte_next;
            bit_index_reg   <= bit_index_next;
            line_count_reg  <= line_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_full_reg <= out_full_next;
    end

    `URLA_ASSERT_ALWAYS(a_count_below_limit, clk, rst_n, line_count_reg < FULL_LEVEL)
    `URLA_ASSERT_IMPLIES(a_data_tick_nonzero, clk, rst_n, phase_reg == PH_DATA, tick_count_reg != '0)
    `URLA_ASSERT_IMPLIES(a_emit_from_stop, clk, rst_n, emit, phase_reg == PH_STOP && in_accept)
    `URLA_ASSERT_IMPLIES(a_full_closes_line, clk, rst_n, out_valid_reg && out_full_reg, out_last_reg)

endmodule

FILE: tb/sv/uart_rx_line_assembler_unit_test.sv
// Testbench for the UART line assembler: line sample stream in, checked byte stream out
`timescale 1ns / 1ps

module uart_rx_line_assembler_unit_test;
    import urla_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [7:0] data;
        logic       line_end;
        logic       full_flush;
    } line_byte_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [0] rx_level
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] data_byte
    logic        m_axis_tlast;           // line_end
    logic        m_axis_tuser;           // [0] full_flush
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;

    logic        line_samples[$];
    line_byte_t  expected_bytes[$];
    int unsigned queued_total = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned snd_idle_pct = 22;
    int unsigned rcv_idle_pct = 71;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;

    logic [15:0] baud_ticks = BIT_TICKS_RESET;
    logic [7:0]  eol_byte = TERM_RESET;
    rx_phase_t   rx_state = PH_IDLE;
    logic [16:0] tick_left = '0;
    logic [7:0]  shift_reg = '0;
    logic [3:0]  bit_cnt = '0;
    logic [11:0] line_len = '0;

    line_byte_t  got_byte;
    line_byte_t  want_byte;
    line_byte_t  next_byte;

    uart_rx_line_assembler_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the receiver by one line sample; return 1 when a byte comes out
    function automatic bit advance_receiver(input logic level, output line_byte_t res);
        logic [16:0] reload;
        logic [16:0] start_wait;
        logic        full_hit;
        logic        term_hit;
        res = '0;
        advance_receiver = 1'b0;
        reload = (baud_ticks == 16'd0) ? 17'd1 : {1'b0, baud_ticks};
        case (rx_state)
            PH_DATA:
            begin
                tick_left = tick_left - 17'd1;
                if (tick_left == 17'd0)
                begin
                    shift_reg = {level, shift_reg[7:1]};
                    bit_cnt = bit_cnt + 4'd1;
                    tick_left = reload;
                    if (bit_cnt >= LAST_BIT)
                        rx_state = PH_STOP;
                end
            end
            PH_STOP:
            begin
                tick_left = tick_left - 17'd1;
                if (tick_left == 17'd0)
                begin
                    rx_state = PH_IDLE;
                    if (shift_reg != 8'd0)
                    begin
                        line_len = line_len + 12'd1;
                        full_hit = (line_len >= FULL_LEVEL);
                        term_hit = (eol_byte != 8'd0) && (shift_reg == eol_byte);
                        if (full_hit || term_hit)
                            line_len = '0;
                        res.data = shift_reg;
                        res.line_end = full_hit || term_hit;
                        res.full_flush = full_hit;
                        advance_receiver = 1'b1;
                    end
                end
            end
            default:
            begin
                rx_state = PH_IDLE;
                if (!level)
                begin
                    rx_state = PH_DATA;
                    shift_reg = '0;
                    bit_cnt = '0;
                    start_wait = {1'b0, baud_ticks} / 17'd3 + {1'b0, baud_ticks};
                    tick_left = (start_wait == 17'd0) ? 17'd1 : start_wait;
                end
            end
        endcase
    endfunction

    task automatic log_error(input string msg);
        if (error_count < 10)
            $display("ERROR: %s", msg);
        error_count++;
    endtask

    // Offer the next line sample once the previous transaction is taken
    always @(posedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (line_samples.size() != 0 && $urandom_range(99) >= snd_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'd0, line_samples.pop_front()};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
        m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_byte = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
                if (expected_bytes.size() == 0)
                begin
                    log_error($sformatf("unexpected byte %02h end %0b full %0b",
                        got_byte.data, got_byte.line_end, got_byte.full_flush));
                end
                else
                begin
                    want_byte = expected_bytes.pop_front();
                    if (got_byte !== want_byte)
                        log_error($sformatf(
                            "got byte %02h end %0b full %0b, expected byte %02h end %0b full %0b",
                            got_byte.data, got_byte.line_end, got_byte.full_flush,
                            want_byte.data, want_byte.line_end, want_byte.full_flush));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (advance_receiver(s_axis_tdata[0], next_byte))
                    expected_bytes.push_back(next_byte);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic push_level(input logic level);
        line_samples.push_back(level);
        queued_total++;
    endtask

    function automatic int unsigned first_sample_tick();
        int unsigned first;
        first = baud_ticks / 3 + baud_ticks;
        return (first == 0) ? 1 : first;
    endfunction

    function automatic int unsigned bit_step();
        return (baud_ticks == 16'd0) ? 1 : baud_ticks;
    endfunction

    // Start bit, eight data bits at their sample ticks, then the stop wait;
    // ticks between samples carry random levels
    task automatic push_frame(input logic [7:0] value);
        int unsigned first;
        int unsigned step;
        int unsigned span;
        first = first_sample_tick();
        step = bit_step();
        span = first + 8 * step;
        push_level(1'b0);
        for (int unsigned t = 1; t <= span; t++)
        begin
            if (t >= first && t < span && (t - first) % step == 0)
                push_level(value[(t - first) / step]);
            else
                push_level(1'($urandom_range(1)));
        end
        repeat ($urandom_range(2)) push_level(1'b1);
    endtask

    task automatic push_idle_tail();
        repeat (first_sample_tick() + 8 * bit_step() + 2) push_level(1'b1);
    endtask

    function automatic logic [7:0] pick_plain_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(1, 255));
        while (v == eol_byte);
        return v;
    endfunction

    // Fill the current line up to the buffer limit, closing it with the given byte
    task automatic push_line_fill(input int unsigned have, input logic [7:0] closer);
        for (int unsigned i = have; i < LINE_BUFFER_BYTES - 2; i++)
            push_frame(pick_plain_byte());
        push_frame(closer);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (line_samples.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_BIT_TICKS)
            baud_ticks = value;
        else
            eol_byte = value[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic start_phase(input logic [15:0] ticks, input logic [7:0] eol);
        drain();
        write_reg(CFG_BIT_TICKS, ticks);
        write_reg(CFG_LINE_TERM, {8'd0, eol});
        @(negedge clk);
    endtask

    task automatic run_mixed_phase();
        start_phase(($urandom_range(7) == 0) ? 16'($urandom_range(2))
                                              : 16'($urandom_range(3, 8)),
                    ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        repeat ($urandom_range(2, 6))
        begin
            case ($urandom_range(9))
                0: repeat ($urandom_range(1, 20)) push_level(1'($urandom_range(1)));
                1: push_frame(8'd0);
                2: push_frame(eol_byte);
                default: push_frame(pick_plain_byte());
            endcase
        end
        push_idle_tail();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        start_phase(16'd0, 8'd0);
        push_frame(8'h00);
        push_frame(8'hFF);
        push_frame(8'h01);
        push_frame(8'h80);
        repeat (12) push_level(1'($urandom_range(1)));
        push_idle_tail();

        start_phase(16'd1, 8'h0A);
        push_frame(8'h0A);
        push_frame(8'h7F);
        push_frame(8'hFE);

        start_phase(16'd2, 8'hFF);
        push_frame(8'hFF);
        push_frame(8'h00);

        start_phase(16'd3, 8'd0);
        push_frame(8'hA5);
        push_frame(8'h5A);

        do
            run_mixed_phase();
        while (queued_total < 300);

        drain();
        snd_idle_pct = 71;
        rcv_idle_pct = 22;
        start_phase(16'd0, 8'($urandom_range(1, 255)));
        hold_req = 1'b1;
        push_line_fill(line_len, eol_byte);

        drain();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        do
            run_mixed_phase();
        while (queued_total < 1800);

        start_phase(16'hFFFF, 8'hFF);
        push_level(1'b0);
        repeat (20) push_level(1'b1);

        drain();
        repeat (10) @(negedge clk);
        if (expected_bytes.size() != 0)
            log_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
